FILE: design/afd_pkg.sv
// Shared types and constants for the AMQP frame deframer.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package afd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_END     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_DONE    = 2'd1,
    RK_ERROR   = 2'd2
  } rkind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TYPE      = 3'd1,
    ERR_SIZE      = 3'd2,
    ERR_END       = 3'd3,
    ERR_HEARTBEAT = 3'd4
  } err_e;

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_e;

  localparam logic [7:0]  END_OCTET      = 8'hCE;
  localparam logic [2:0]  HDR_LAST       = 3'd6;
  localparam logic [2:0]  HDR_CHAN_LAST  = 3'd2;
  localparam logic [7:0]  TYPE_METHOD    = 8'd1;
  localparam logic [7:0]  TYPE_HEADER    = 8'd2;
  localparam logic [7:0]  TYPE_BODY      = 8'd3;
  localparam logic [7:0]  TYPE_HEARTBEAT = 8'd8;
  localparam logic [32:0] FRAME_OVERHEAD = 33'd8;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    rkind_e      result_kind;
    logic [7:0]  frame_type;
    logic [15:0] channel;
    logic [7:0]  payload_byte;
    err_e        error_code;
  } res_t;

endpackage

`default_nettype wire

FILE: design/afd_in_stage.sv
// Input register of the deframer: holds one accepted beat for the parser.
// Depends on afd_pkg.
`default_nettype none

module afd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  afd_pkg::item_t item_i,
  output logic          item_valid_o,
  input  logic          item_taken_i,
  output afd_pkg::item_t item_o
);
  import afd_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_ready_o   = !valid_q || item_taken_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/afd_parser.sv
// Frame parser: header assembly, frame checks, payload count and sticky error.
// Holds the frame size limit register. Depends on afd_pkg.
`default_nettype none

module afd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          item_valid_i,
  input  afd_pkg::item_t item_i,
  input  logic          slot_free_i,
  output logic          item_taken_o,
  output logic          res_valid_o,
  output afd_pkg::res_t res_o
);
  import afd_pkg::*;

  logic [31:0] max_len_q;
  phase_e      phase_q, phase_d;
  logic [2:0]  hc_q, hc_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] channel_q, channel_d;
  logic [31:0] size_q, size_d;
  logic [31:0] rem_q, rem_d;
  logic        failed_q, failed_d;
  err_e        err_q, err_d;
  logic        has_res;
  rkind_e      rk;
  logic [7:0]  pbyte;
  err_e        ecode;
  logic [32:0] frame_total;
  logic        known_type;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '0;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    hc_d     = hc_q;
    type_d   = type_q;
    channel_d = channel_q;
    size_d   = size_q;
    rem_d    = rem_q;
    failed_d = failed_q;
    err_d    = err_q;
    has_res  = 1'b0;
    rk       = RK_PAYLOAD;
    pbyte    = '0;
    ecode    = ERR_NONE;
    frame_total = '0;
    known_type  = 1'b0;
    if (item_i.kind == KIND_CLEAR) begin
      phase_d   = PH_HEADER;
      hc_d      = '0;
      type_d    = '0;
      channel_d = '0;
      size_d    = '0;
      rem_d     = '0;
      failed_d  = 1'b0;
      err_d     = ERR_NONE;
    end else if (failed_q) begin
      has_res = 1'b1;
      rk      = RK_ERROR;
      ecode   = err_q;
    end else begin
      case (phase_q)
        PH_PAYLOAD: begin
          rem_d   = rem_q - 32'd1;
          if (rem_q == 32'd1) begin
            phase_d = PH_END;
          end
          has_res = 1'b1;
          rk      = RK_PAYLOAD;
          pbyte   = item_i.data;
        end
        PH_END: begin
          has_res = 1'b1;
          if (item_i.data != END_OCTET) begin
            failed_d = 1'b1;
            err_d    = ERR_END;
            rk       = RK_ERROR;
            ecode    = ERR_END;
          end else begin
            phase_d = PH_HEADER;
            hc_d    = '0;
            rk      = RK_DONE;
          end
        end
        default: begin
          phase_d = PH_HEADER;
          if (hc_q == 3'd0) begin
            type_d = item_i.data;
          end else if (hc_q <= HDR_CHAN_LAST) begin
            channel_d = {channel_q[7:0], item_i.data};
          end else begin
            size_d = {size_q[23:0], item_i.data};
          end
          hc_d        = hc_q + 3'd1;
          frame_total = {1'b0, size_d} + FRAME_OVERHEAD;
          known_type  = type_d inside {TYPE_METHOD, TYPE_HEADER, TYPE_BODY, TYPE_HEARTBEAT};
          if (hc_q == HDR_LAST) begin
            hc_d = '0;
            if (!known_type) begin
              ecode = ERR_TYPE;
            end else if (max_len_q != '0 && frame_total > {1'b0, max_len_q}) begin
              ecode = ERR_SIZE;
            end else if (type_d == TYPE_HEARTBEAT && (channel_d != '0 || size_d != '0)) begin
              ecode = ERR_HEARTBEAT;
            end
            if (ecode != ERR_NONE) begin
              has_res  = 1'b1;
              rk       = RK_ERROR;
              failed_d = 1'b1;
              err_d    = ecode;
            end else begin
              rem_d   = size_d;
              phase_d = (size_d == '0) ? PH_END : PH_PAYLOAD;
            end
          end
        end
      endcase
    end
  end

  assign item_taken_o = item_valid_i && (!has_res || slot_free_i);
  assign res_valid_o  = item_taken_o && has_res;

  assign res_o.result_kind  = rk;
  assign res_o.frame_type   = type_d;
  assign res_o.channel      = channel_d;
  assign res_o.payload_byte = pbyte;
  assign res_o.error_code   = ecode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hc_q      <= '0;
      type_q    <= '0;
      channel_q <= '0;
      size_q    <= '0;
      rem_q     <= '0;
      failed_q  <= 1'b0;
      err_q     <= ERR_NONE;
    end else if (item_taken_o) begin
      phase_q   <= phase_d;
      hc_q      <= hc_d;
      type_q    <= type_d;
      channel_q <= channel_d;
      size_q    <= size_d;
      rem_q     <= rem_d;
      failed_q  <= failed_d;
      err_q     <= err_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/afd_out_stage.sv
// Result register of the deframer: holds one result beat until it is taken.
// Depends on afd_pkg.
`default_nettype none

module afd_out_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  input  afd_pkg::res_t res_i,
  output logic         slot_free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output afd_pkg::res_t res_o
);
  import afd_pkg::*;

  logic valid_q;
  res_t res_q;

  assign slot_free_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && slot_free_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/amqp_frame_deframer.sv
// Top level of the AMQP 0-9-1 frame deframer.
// Depends on afd_pkg, afd_in_stage, afd_parser and afd_out_stage.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  ---------------------------------------------
//  in       in_valid_i / in_ready_o  kind_i, data_i
//  out      out_valid_o / out_ready_i result_kind_o, frame_type_o, channel_o,
//                                    payload_byte_o, error_code_o
//  cfg      cfg_we_i                 cfg_wdata_i (frame size limit)
//
// One beat is accepted per cycle while the parser can take it; a beat that yields a
// result passes through the input register and the parser into the result register.
// The parser is combinational between the input register and the result register.
// A stalled result holds the next result-bearing beat in the input register; beats that yield no result keep flowing.
// Reset clears the parser state and the size limit; there is no clearing pass.
`default_nettype none

module amqp_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  frame_type_o,
  output logic [15:0] channel_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  error_code_o
);
  import afd_pkg::*;

  item_t item_in, item;
  logic  item_valid, item_taken, slot_free, res_valid;
  res_t  res, res_out;

  assign item_in.kind = kind_e'(kind_i);
  assign item_in.data = data_i;

  afd_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_taken_i (item_taken),
    .item_o       (item)
  );

  afd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .slot_free_i  (slot_free),
    .item_taken_o (item_taken),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  afd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign result_kind_o  = res_out.result_kind;
  assign frame_type_o   = res_out.frame_type;
  assign channel_o      = res_out.channel;
  assign payload_byte_o = res_out.payload_byte;
  assign error_code_o   = res_out.error_code;

endmodule

`default_nettype wire

FILE: design/afd_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on afd_pkg and amqp_frame_deframer.
`default_nettype none

module afd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [2:0]  error_code_o
);
  import afd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(error_code_o) && $stable(payload_byte_o))
    else $error("Stalled result beat changed.");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o == RK_PAYLOAD || result_kind_o == RK_DONE
      || result_kind_o == RK_ERROR)
    else $error("Result kind out of range.");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_ERROR |-> error_code_o != ERR_NONE
      && error_code_o <= ERR_HEARTBEAT && payload_byte_o == 8'd0)
    else $error("Error beat without a valid error code.");

  a_ok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RK_ERROR |-> error_code_o == ERR_NONE
      && (result_kind_o != RK_DONE || payload_byte_o == 8'd0))
    else $error("Non-error beat carries stray fields.");

endmodule

bind amqp_frame_deframer afd_checker u_afd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .payload_byte_o (payload_byte_o),
  .error_code_o   (error_code_o)
);

`default_nettype wire
